FILE: hdl/buddy_page_allocator_macros.svh
// Assertion macros shared by the buddy page allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BPA_CHECK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one on the next edge.
`define BPA_CHECK_NEXT(name, clk, rst, cause, effect, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

FILE: hdl/bpa_pkg.sv
// Shared types, constants and helper functions of the buddy page allocator.
// No dependencies; used by bpa_ctrl, bpa_datapath and the top level.
package bpa_pkg;

   localparam int LEVEL_LIMIT = 10;
   localparam int NODE_COUNT  = (1 << (LEVEL_LIMIT + 1)) - 1;
   localparam int ADDR_W      = 11;
   localparam int PAGE_W      = 10;
   localparam int COUNT_W     = 11;
   localparam int LVL_W       = 4;
   localparam int NODE_W      = 4;

   // Node codes; they sort above every level, as the allocator expects.
   localparam logic [NODE_W-1:0] CODE_FILLED    = 4'd15;
   localparam logic [NODE_W-1:0] CODE_ALLOCATED = 4'd14;
   localparam logic [NODE_W-1:0] CODE_UNUSABLE  = 4'd13;

   localparam logic [2:0] ACT_INIT    = 3'd0;
   localparam logic [2:0] ACT_RESERVE = 3'd1;
   localparam logic [2:0] ACT_READY   = 3'd2;
   localparam logic [2:0] ACT_ALLOC   = 3'd3;
   localparam logic [2:0] ACT_FREE    = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_SPACE  = 3'd1;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
   localparam logic [2:0] ST_PHASE     = 3'd4;
   localparam logic [2:0] ST_RANGE     = 3'd5;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT_WR, S_RSV_WR, S_RDY_RD, S_RDY_WR,
      S_AL_ROOT_RD, S_AL_ROOT_EV, S_AL_EVAL, S_AL_SPLIT_A, S_AL_SPLIT_B,
      S_AL_SPLIT_C, S_AL_CH_RD, S_AL_CH_EV, S_AL_MARK, S_RF_RD, S_RF_WR,
      S_FR_RD, S_FR_EV, S_FR_SET, S_MG_RD, S_MG_EV, S_DONE
   } ctl_state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_START_INIT, DP_START_RSV, DP_START_RDY, DP_START_WALK,
      DP_INIT_WR, DP_RSV_WR, DP_RD_CH, DP_RDY_WR, DP_RD_IDX, DP_CAP,
      DP_SPLIT_A, DP_SPLIT_B, DP_SPLIT_C, DP_CH_SEL, DP_MARK, DP_RD_PAIR,
      DP_RF_WR, DP_FR_STEP, DP_FR_SET, DP_MG_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       accept;
      logic       status_we;
      logic [2:0] status;
      logic       set_ready;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic init_bad;
      logic init_done;
      logic ready;
      logic rsv_range_bad;
      logic size_bad;
      logic page_bad;
      logic top_zero;
      logic init_last;
      logic rsv_last;
      logic root_no_space;
      logic cv_eq_lvl;
      logic lvl_eq_al;
      logic lvl_ge_top;
      logic idx_zero;
      logic parent_zero;
      logic node_alloc;
      logic fr_stop;
      logic mg_match;
      logic rsp_free;
   } dp_flags_type;

   // Smallest l with 2^l >= n, for n in 1 .. 2^LEVEL_LIMIT.
   function automatic logic [LVL_W-1:0] ceil_log2(input logic [COUNT_W-1:0] n);
      logic [LVL_W-1:0] r;
      r = '0;
      for (int l = LEVEL_LIMIT; l >= 0; l--) begin
         if ((12'(1) << l) >= {1'b0, n}) r = LVL_W'(l);
      end
      return r;
   endfunction

   // Tree level of a node index: floor(log2(index + 1)).
   function automatic logic [LVL_W-1:0] node_level(input logic [ADDR_W-1:0] idx);
      logic [ADDR_W:0]  v;
      logic [LVL_W-1:0] r;
      v = {1'b0, idx} + 12'd1;
      r = '0;
      for (int l = 0; l <= ADDR_W; l++) begin
         if (v[l]) r = LVL_W'(l);
      end
      return r;
   endfunction

endpackage

FILE: hdl/buddy_page_allocator.sv
// Top level of the buddy page allocator: stream ports, controller and datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
//   Channel  Direction  Beat contents
//   req_*    in         action, request_pages, start_page, end_page
//   rsp_*    out        status, first_page (one beat per request beat)
//   csr_*    in         total_pages, written without handshake
//
// One request is worked at a time; a new beat is taken once the previous
// result sits in the output register. With T the top tree level, init writes
// all 2^T leaves, reserve marks each page of its range, ready reads the two
// children of each inner node and writes it, and allocate or free walk down
// the tree and back up, all paced by the single write port of the node
// memory. Reset is synchronous and clears the phase flags; the node memory is
// not cleared and is first read only after init has written it. A stalled
// result beat holds the controller in its final state and blocks new requests.
module buddy_page_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [2:0] action, [13:3] request_pages, [23:14] start_page, [33:24] end_page
   input  logic [39:0]                 req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [2:0] status, [12:3] first_page
   output logic [15:0]                 rsp_tdata,
   input  logic                        csr_we,
   input  logic [bpa_pkg::COUNT_W-1:0] csr_wdata
);
   import bpa_pkg::*;

   dp_cmd_type        cmd;
   dp_flags_type      flags;
   logic [2:0]        rsp_status;
   logic [PAGE_W-1:0] rsp_first;

   // The controller only needs the action; the datapath sees the operands.
   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tdata[2:0]),
      .flags      (flags),
      .cmd        (cmd)
   );

   bpa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_pages  (req_tdata[13:3]),
      .req_start  (req_tdata[23:14]),
      .req_end    (req_tdata[33:24]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_first  (rsp_first)
   );

   // Upper response bits are padding and are held at zero.
   assign rsp_tdata = {3'b000, rsp_first, rsp_status};

endmodule

FILE: hdl/bpa_ctrl.sv
// Controller of the buddy page allocator: sequences every action.
// Depends on bpa_pkg; drives bpa_datapath through command and flag structs.
module bpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_action,
   input  bpa_pkg::dp_flags_type flags,
   output bpa_pkg::dp_cmd_type   cmd
);
   import bpa_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_INIT:    state_in = flags.init_bad ? S_DONE : S_INIT_WR;
                  ACT_RESERVE: begin
                     if (!flags.init_done || flags.ready || flags.rsv_range_bad)
                        state_in = S_DONE;
                     else
                        state_in = S_RSV_WR;
                  end
                  ACT_READY: begin
                     if (!flags.init_done || flags.ready || flags.top_zero)
                        state_in = S_DONE;
                     else
                        state_in = S_RDY_RD;
                  end
                  ACT_ALLOC:
                     state_in = (!flags.ready || flags.size_bad) ? S_DONE : S_AL_ROOT_RD;
                  ACT_FREE:
                     state_in = (!flags.ready || flags.page_bad) ? S_DONE : S_FR_RD;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_INIT_WR:    if (flags.init_last) state_in = S_DONE;
         S_RSV_WR:     if (flags.rsv_last) state_in = S_DONE;
         S_RDY_RD:     state_in = S_RDY_WR;
         S_RDY_WR:     state_in = flags.idx_zero ? S_DONE : S_RDY_RD;
         S_AL_ROOT_RD: state_in = S_AL_ROOT_EV;
         S_AL_ROOT_EV: state_in = flags.root_no_space ? S_DONE : S_AL_EVAL;
         S_AL_EVAL: begin
            if (flags.cv_eq_lvl)
               state_in = flags.lvl_eq_al ? S_AL_MARK : S_AL_SPLIT_A;
            else
               state_in = flags.lvl_ge_top ? S_DONE : S_AL_CH_RD;
         end
         S_AL_SPLIT_A: state_in = S_AL_SPLIT_B;
         S_AL_SPLIT_B: state_in = S_AL_SPLIT_C;
         S_AL_SPLIT_C: state_in = flags.lvl_ge_top ? S_DONE : S_AL_CH_RD;
         S_AL_CH_RD:   state_in = S_AL_CH_EV;
         S_AL_CH_EV:   state_in = S_AL_EVAL;
         S_AL_MARK:    state_in = flags.idx_zero ? S_DONE : S_RF_RD;
         S_RF_RD:      state_in = S_RF_WR;
         S_RF_WR:      state_in = flags.parent_zero ? S_DONE : S_RF_RD;
         S_FR_RD:      state_in = S_FR_EV;
         S_FR_EV: begin
            priority if (flags.node_alloc) state_in = S_FR_SET;
            else if (flags.fr_stop)        state_in = S_DONE;
            else                           state_in = S_FR_RD;
         end
         S_FR_SET:     state_in = flags.idx_zero ? S_DONE : S_MG_RD;
         S_MG_RD:      state_in = S_MG_EV;
         S_MG_EV: begin
            if (flags.mg_match) state_in = flags.parent_zero ? S_DONE : S_MG_RD;
            else                state_in = S_RF_RD;
         end
         S_DONE:       if (flags.rsp_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd           = '0;
      cmd.op        = DP_NOP;
      cmd.status    = ST_OK;
      cmd.accept    = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.status_we = 1'b1;
               unique case (req_action)
                  ACT_INIT: begin
                     if (flags.init_bad) cmd.status = ST_BAD_SIZE;
                     else                cmd.op     = DP_START_INIT;
                  end
                  ACT_RESERVE: begin
                     priority if (!flags.init_done || flags.ready) cmd.status = ST_PHASE;
                     else if (flags.rsv_range_bad)                 cmd.status = ST_RANGE;
                     else                                          cmd.op = DP_START_RSV;
                  end
                  ACT_READY: begin
                     priority if (!flags.init_done || flags.ready) cmd.status = ST_PHASE;
                     else if (flags.top_zero)                      cmd.set_ready = 1'b1;
                     else                                          cmd.op = DP_START_RDY;
                  end
                  ACT_ALLOC: begin
                     priority if (!flags.ready) cmd.status = ST_PHASE;
                     else if (flags.size_bad)   cmd.status = ST_BAD_SIZE;
                     else                       cmd.op     = DP_START_WALK;
                  end
                  ACT_FREE: begin
                     priority if (!flags.ready) cmd.status = ST_PHASE;
                     else if (flags.page_bad)   cmd.status = ST_RANGE;
                     else                       cmd.op     = DP_START_WALK;
                  end
                  default: cmd.status = ST_RANGE;
               endcase
            end
         end
         S_INIT_WR:    cmd.op = DP_INIT_WR;
         S_RSV_WR:     cmd.op = DP_RSV_WR;
         S_RDY_RD:     cmd.op = DP_RD_CH;
         S_RDY_WR: begin
            cmd.op        = DP_RDY_WR;
            cmd.set_ready = flags.idx_zero;
         end
         S_AL_ROOT_RD: cmd.op = DP_RD_IDX;
         S_AL_ROOT_EV: begin
            cmd.op        = DP_CAP;
            cmd.status_we = flags.root_no_space;
            cmd.status    = ST_NO_SPACE;
         end
         S_AL_EVAL: begin
            cmd.status_we = !flags.cv_eq_lvl && flags.lvl_ge_top;
            cmd.status    = ST_NO_SPACE;
         end
         S_AL_SPLIT_A: cmd.op = DP_SPLIT_A;
         S_AL_SPLIT_B: cmd.op = DP_SPLIT_B;
         S_AL_SPLIT_C: begin
            cmd.op        = DP_SPLIT_C;
            cmd.status_we = flags.lvl_ge_top;
            cmd.status    = ST_NO_SPACE;
         end
         S_AL_CH_RD:   cmd.op = DP_RD_CH;
         S_AL_CH_EV:   cmd.op = DP_CH_SEL;
         S_AL_MARK:    cmd.op = DP_MARK;
         S_RF_RD:      cmd.op = DP_RD_PAIR;
         S_RF_WR:      cmd.op = DP_RF_WR;
         S_FR_RD:      cmd.op = DP_RD_IDX;
         S_FR_EV: begin
            cmd.op        = DP_FR_STEP;
            cmd.status_we = !flags.node_alloc && flags.fr_stop;
            cmd.status    = ST_NOT_ALLOC;
         end
         S_FR_SET:     cmd.op = DP_FR_SET;
         S_MG_RD:      cmd.op = DP_RD_PAIR;
         S_MG_EV:      cmd.op = DP_MG_STEP;
         S_DONE:       cmd.emit = flags.rsp_free;
         default:      cmd.op = DP_NOP;
      endcase
   end

endmodule

FILE: hdl/bpa_datapath.sv
// Datapath of the buddy page allocator: node memory, walk registers, result slot.
// Depends on bpa_pkg and buddy_page_allocator_macros.svh; commanded by bpa_ctrl.
module bpa_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  bpa_pkg::dp_cmd_type         cmd,
   output bpa_pkg::dp_flags_type       flags,
   input  logic                        csr_we,
   input  logic [bpa_pkg::COUNT_W-1:0] csr_wdata,
   input  logic [bpa_pkg::COUNT_W-1:0] req_pages,
   input  logic [bpa_pkg::PAGE_W-1:0]  req_start,
   input  logic [bpa_pkg::PAGE_W-1:0]  req_end,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [2:0]                  rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]  rsp_first
);
   import bpa_pkg::*;
`include "buddy_page_allocator_macros.svh"

   logic [NODE_W-1:0] mem [NODE_COUNT];
   logic [NODE_W-1:0] rd0_ff, rd1_ff;
   logic [ADDR_W-1:0] raddr0, raddr1, waddr;
   logic [NODE_W-1:0] wdata;
   logic              we;

   logic [COUNT_W-1:0] total_ff;
   logic               init_done_ff, init_done_in, ready_ff, ready_in;
   logic [LVL_W-1:0]   top_ff, top_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in, al_ff, al_in, cv_ff, cv_in;
   logic [PAGE_W-1:0]  cnt_ff, cnt_in, end_ff, end_in, page_ff, page_in;
   logic [PAGE_W-1:0]  first_ff, first_in;
   logic [2:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff;
   logic [PAGE_W-1:0]  rsp_first_ff;

   logic [ADDR_W-1:0]  off, left_idx, right_idx, sib_idx, parent_idx, pos;
   logic [COUNT_W-1:0] top_pages;
   logic [LVL_W-1:0]   lvl_p1, shamt, nl, min01;
   logic               go_right, page_bit;

   always_comb begin
      off        = (ADDR_W'(1) << top_ff) - ADDR_W'(1);
      top_pages  = COUNT_W'(1) << top_ff;
      left_idx   = {idx_ff[ADDR_W-2:0], 1'b1};
      right_idx  = left_idx + ADDR_W'(1);
      sib_idx    = idx_ff[0] ? idx_ff + ADDR_W'(1) : idx_ff - ADDR_W'(1);
      parent_idx = (idx_ff - ADDR_W'(1)) >> 1;
      lvl_p1     = lvl_ff + LVL_W'(1);
      shamt      = top_ff - lvl_p1;
      page_bit   = page_ff[shamt];
      nl         = node_level(idx_ff);
      min01      = (rd0_ff < rd1_ff) ? rd0_ff : rd1_ff;
      pos        = idx_ff + ADDR_W'(1) - (ADDR_W'(1) << lvl_ff);
      if (rd0_ff < rd1_ff) go_right = (al_ff >= rd1_ff);
      else                 go_right = !(al_ff >= rd0_ff);
   end

   always_comb begin
      flags.init_bad      = (total_ff == '0) || (total_ff > COUNT_W'(1 << LEVEL_LIMIT));
      flags.init_done     = init_done_ff;
      flags.ready         = ready_ff;
      flags.rsv_range_bad = (req_start > req_end) || ({1'b0, req_end} >= top_pages);
      flags.size_bad      = (req_pages == '0) || (req_pages > top_pages);
      flags.page_bad      = ({1'b0, req_start} >= top_pages);
      flags.top_zero      = (top_ff == '0);
      flags.init_last     = (cnt_ff == off[PAGE_W-1:0]);
      flags.rsv_last      = (cnt_ff == end_ff);
      flags.root_no_space = (al_ff < rd0_ff);
      flags.cv_eq_lvl     = (cv_ff == lvl_ff);
      flags.lvl_eq_al     = (lvl_ff == al_ff);
      flags.lvl_ge_top    = (lvl_ff >= top_ff);
      flags.idx_zero      = (idx_ff == '0);
      flags.parent_zero   = (parent_idx == '0);
      flags.node_alloc    = (rd0_ff == CODE_ALLOCATED);
      flags.fr_stop       = (rd0_ff == lvl_ff) || (rd0_ff == CODE_UNUSABLE)
                            || (lvl_ff >= top_ff);
      flags.mg_match      = (rd0_ff == lvl_ff);
      flags.rsp_free      = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      raddr0       = idx_ff;
      raddr1       = idx_ff;
      we           = 1'b0;
      waddr        = idx_ff;
      wdata        = '0;
      init_done_in = init_done_ff;
      ready_in     = ready_ff || cmd.set_ready;
      top_in       = top_ff;
      idx_in       = idx_ff;
      lvl_in       = lvl_ff;
      al_in        = al_ff;
      cv_in        = cv_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      page_in      = page_ff;
      first_in     = cmd.accept ? '0 : first_ff;
      status_in    = cmd.status_we ? cmd.status : status_ff;
      unique case (cmd.op)
         DP_NOP: ;
         DP_START_INIT: begin
            top_in       = ceil_log2(total_ff);
            init_done_in = 1'b1;
            ready_in     = 1'b0;
            cnt_in       = '0;
         end
         DP_START_RSV: begin
            cnt_in = req_start;
            end_in = req_end;
         end
         DP_START_RDY: idx_in = off - ADDR_W'(1);
         DP_START_WALK: begin
            idx_in  = '0;
            lvl_in  = '0;
            page_in = req_start;
            al_in   = top_ff - ceil_log2(req_pages);
         end
         DP_INIT_WR: begin
            we     = 1'b1;
            waddr  = off + ADDR_W'(cnt_ff);
            wdata  = ({1'b0, cnt_ff} < total_ff) ? top_ff : CODE_UNUSABLE;
            cnt_in = cnt_ff + PAGE_W'(1);
         end
         DP_RSV_WR: begin
            we     = 1'b1;
            waddr  = off + ADDR_W'(cnt_ff);
            wdata  = CODE_UNUSABLE;
            cnt_in = cnt_ff + PAGE_W'(1);
         end
         DP_RD_CH: begin
            raddr0 = left_idx;
            raddr1 = right_idx;
         end
         DP_RDY_WR: begin
            we = 1'b1;
            if (rd0_ff == CODE_UNUSABLE && rd1_ff == CODE_UNUSABLE)
               wdata = CODE_UNUSABLE;
            else if (rd0_ff == nl + LVL_W'(1) && rd1_ff == nl + LVL_W'(1))
               wdata = nl;
            else
               wdata = min01;
            idx_in = idx_ff - ADDR_W'(1);
         end
         DP_RD_IDX: raddr0 = idx_ff;
         DP_CAP:    cv_in  = rd0_ff;
         DP_SPLIT_A: begin
            we    = 1'b1;
            wdata = lvl_p1;
         end
         DP_SPLIT_B: begin
            we    = 1'b1;
            waddr = left_idx;
            wdata = lvl_p1;
         end
         DP_SPLIT_C: begin
            we    = 1'b1;
            waddr = right_idx;
            wdata = lvl_p1;
         end
         DP_CH_SEL: begin
            idx_in = go_right ? right_idx : left_idx;
            cv_in  = go_right ? rd1_ff : rd0_ff;
            lvl_in = lvl_p1;
         end
         DP_MARK: begin
            we       = 1'b1;
            wdata    = CODE_ALLOCATED;
            first_in = PAGE_W'(pos << (top_ff - lvl_ff));
         end
         DP_RD_PAIR: begin
            raddr0 = sib_idx;
            raddr1 = idx_ff;
         end
         DP_RF_WR: begin
            we     = 1'b1;
            waddr  = parent_idx;
            wdata  = (min01 > top_ff) ? CODE_FILLED : min01;
            idx_in = parent_idx;
         end
         DP_FR_STEP: begin
            if (!flags.node_alloc && !flags.fr_stop) begin
               idx_in = page_bit ? right_idx : left_idx;
               lvl_in = lvl_p1;
            end
         end
         DP_FR_SET: begin
            we    = 1'b1;
            wdata = lvl_ff;
         end
         DP_MG_STEP: begin
            if (flags.mg_match) begin
               we     = 1'b1;
               waddr  = parent_idx;
               wdata  = lvl_ff - LVL_W'(1);
               idx_in = parent_idx;
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd0_ff <= mem[raddr0];
      rd1_ff <= mem[raddr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= COUNT_W'(1 << LEVEL_LIMIT);
         init_done_ff <= 1'b0;
         ready_ff     <= 1'b0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) total_ff <= csr_wdata;
         init_done_ff <= init_done_in;
         ready_ff     <= ready_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      lvl_ff    <= lvl_in;
      al_ff     <= al_in;
      cv_ff     <= cv_in;
      cnt_ff    <= cnt_in;
      end_ff    <= end_in;
      page_ff   <= page_in;
      first_ff  <= first_in;
      status_ff <= status_in;
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_first_ff  <= (status_ff == ST_OK) ? first_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_first  = rsp_first_ff;

   `BPA_CHECK(a_waddr_in_tree, clock, reset, !we || (waddr < ADDR_W'(NODE_COUNT)), "node write outside the tree")
   `BPA_CHECK(a_ready_needs_init, clock, reset, !ready_ff || init_done_ff, "ready without init")
   `BPA_CHECK_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff, "emitted result not shown")
   `BPA_CHECK(a_first_zero_on_error, clock, reset, !rsp_valid_ff || (rsp_status_ff == ST_OK) || (rsp_first_ff == '0), "first page set on error")

endmodule

FILE: tb/tb_buddy_page_allocator.sv
// Self-checking testbench for the buddy page allocator: drives request beats,
// predicts every result beat and checks the status and first page fields.
// Depends on bpa_pkg and the buddy_page_allocator RTL only.
module tb_buddy_page_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   // Node codes of the predictor; they sort above every tree level.
   localparam int unsigned N_FILLED    = 255;
   localparam int unsigned N_ALLOCATED = 254;
   localparam int unsigned N_UNUSABLE  = 253;
   localparam int unsigned TREE_SIZE   = (1 << (LEVEL_LIMIT + 1)) - 1;
   localparam int unsigned CYCLE_LIMIT = 12000000;
   localparam int unsigned MAX_SHOWN   = 10;
   localparam logic [2:0]  ACT_BOGUS_LO = 3'd5;
   localparam logic [2:0]  ACT_BOGUS_HI = 3'd7;

   typedef struct {
      logic [2:0]        status;
      logic [PAGE_W-1:0] first_page;
   } alloc_answer_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // [2:0] action, [13:3] request_pages, [23:14] start_page, [33:24] end_page
   logic [39:0]         req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // [2:0] status, [12:3] first_page
   logic [15:0]         rsp_tdata;
   logic                csr_we;
   logic [COUNT_W-1:0]  csr_wdata;

   buddy_page_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Request beats waiting to be driven and answers waiting to be seen.
   logic [39:0]      pending_reqs[$];
   alloc_answer_type awaited_answers[$];

   // Predictor state: the node tree, phase flags and latched configuration.
   int unsigned tree_q [TREE_SIZE];
   bit          is_ready;
   bit          was_inited;
   int unsigned top_lvl;
   int unsigned page_count;

   int unsigned send_idle;
   int unsigned recv_idle;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned beats_sent;
   int unsigned beats_checked;
   int unsigned allocs_ok;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor. Levels count down from the root (level 0); a node holds the
   // smallest level of a wholly free block beneath it, or one of the codes.
   // ---------------------------------------------------------------------
   function automatic int unsigned depth_of(int unsigned idx);
      int unsigned d;
      int unsigned v;
      d = 0;
      v = idx + 1;
      while (v > 1) begin
         v = v >> 1;
         d++;
      end
      return d;
   endfunction

   function automatic int unsigned log2_up(int unsigned v);
      int unsigned d;
      d = 0;
      while (d < 31 && (1 << d) < v) d++;
      return d;
   endfunction

   function automatic int unsigned node_get(int unsigned i);
      return (i < TREE_SIZE) ? tree_q[i] : N_UNUSABLE;
   endfunction

   function automatic void node_put(int unsigned i, int unsigned v);
      if (i < TREE_SIZE) tree_q[i] = v;
   endfunction

   function automatic int unsigned page_of_block(int unsigned idx);
      int unsigned d;
      d = depth_of(idx);
      if (d > top_lvl) return 0;
      return (idx - ((1 << d) - 1)) << (top_lvl - d);
   endfunction

   // Recomputes every ancestor of a node from its two children.
   function automatic void refresh_ancestors(int unsigned b);
      int unsigned par;
      int unsigned sib;
      int unsigned m;
      while (b != 0) begin
         par = (b - 1) / 2;
         sib = b[0] ? b + 1 : b - 1;
         m = (node_get(b) < node_get(sib)) ? node_get(b) : node_get(sib);
         node_put(par, (m > top_lvl) ? N_FILLED : m);
         b = par;
      end
   endfunction

   function automatic logic [2:0] model_init();
      int unsigned base;
      if (page_count == 0 || page_count > (1 << LEVEL_LIMIT)) return ST_BAD_SIZE;
      top_lvl = log2_up(page_count);
      base = (1 << top_lvl) - 1;
      for (int unsigned i = base; i < (2 << top_lvl) - 1; i++)
         node_put(i, (i - base < page_count) ? top_lvl : N_UNUSABLE);
      is_ready = 1'b0;
      was_inited = 1'b1;
      return ST_OK;
   endfunction

   function automatic logic [2:0] model_reserve(int unsigned lo, int unsigned hi);
      if (!was_inited || is_ready) return ST_PHASE;
      if (lo > hi || hi >= (1 << top_lvl)) return ST_RANGE;
      for (int unsigned p = lo; p <= hi; p++) node_put((1 << top_lvl) - 1 + p, N_UNUSABLE);
      return ST_OK;
   endfunction

   function automatic logic [2:0] model_ready();
      int unsigned d;
      int unsigned lv;
      int unsigned rv;
      if (!was_inited || is_ready) return ST_PHASE;
      for (int b = (1 << top_lvl) - 2; b >= 0; b--) begin
         d = depth_of(b);
         lv = node_get(2 * b + 1);
         rv = node_get(2 * b + 2);
         if (lv == N_UNUSABLE && rv == N_UNUSABLE) node_put(b, N_UNUSABLE);
         else if (lv == d + 1 && rv == d + 1) node_put(b, d);
         else node_put(b, (lv < rv) ? lv : rv);
      end
      is_ready = 1'b1;
      return ST_OK;
   endfunction

   // Descends toward the tighter-fitting child, splitting free blocks on the way.
   function automatic logic [2:0] model_alloc(int unsigned n, output int unsigned first);
      int unsigned want;
      int unsigned d;
      int unsigned idx;
      int unsigned lv;
      int unsigned rv;
      first = 0;
      d = 0;
      idx = 0;
      if (!is_ready) return ST_PHASE;
      if (n == 0 || n > (1 << top_lvl)) return ST_BAD_SIZE;
      want = top_lvl - log2_up(n);
      if (want < node_get(0)) return ST_NO_SPACE;
      forever begin
         if (node_get(idx) == d) begin
            if (d == want) break;
            node_put(idx, d + 1);
            node_put(2 * idx + 1, d + 1);
            node_put(2 * idx + 2, d + 1);
         end
         if (d >= top_lvl) return ST_NO_SPACE;
         lv = node_get(2 * idx + 1);
         rv = node_get(2 * idx + 2);
         if (lv < rv) idx = (want >= rv) ? 2 * idx + 2 : 2 * idx + 1;
         else idx = (want >= lv) ? 2 * idx + 1 : 2 * idx + 2;
         d++;
      end
      node_put(idx, N_ALLOCATED);
      refresh_ancestors(idx);
      first = page_of_block(idx);
      return ST_OK;
   endfunction

   // Finds the allocated block over a page, frees it and merges free buddies.
   function automatic logic [2:0] model_free(int unsigned page);
      int unsigned idx;
      int unsigned v;
      int unsigned sib;
      int unsigned par;
      idx = 0;
      if (!is_ready) return ST_PHASE;
      if (page >= (1 << top_lvl)) return ST_RANGE;
      for (int unsigned d = 0; ; d++) begin
         v = node_get(idx);
         if (v == N_ALLOCATED) break;
         if (v == d || v == N_UNUSABLE || d >= top_lvl) return ST_NOT_ALLOC;
         idx = (page >= page_of_block(2 * idx + 2)) ? 2 * idx + 2 : 2 * idx + 1;
      end
      node_put(idx, depth_of(idx));
      while (idx != 0) begin
         sib = idx[0] ? idx + 1 : idx - 1;
         if (node_get(sib) != depth_of(idx)) break;
         par = (idx - 1) / 2;
         node_put(par, depth_of(par));
         idx = par;
      end
      refresh_ancestors(idx);
      return ST_OK;
   endfunction

   function automatic alloc_answer_type predict_answer(logic [39:0] beat);
      alloc_answer_type a;
      int unsigned      first;
      first = 0;
      case (beat[2:0])
         ACT_INIT:    a.status = model_init();
         ACT_RESERVE: a.status = model_reserve(32'(beat[23:14]), 32'(beat[33:24]));
         ACT_READY:   a.status = model_ready();
         ACT_ALLOC:   a.status = model_alloc(32'(beat[13:3]), first);
         ACT_FREE:    a.status = model_free(32'(beat[23:14]));
         default:     a.status = ST_RANGE;
      endcase
      if (a.status != ST_OK) first = 0;
      a.first_page = first[PAGE_W-1:0];
      return a;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one beat in flight; the prediction is made at acceptance.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            awaited_answers.push_back(predict_answer(req_tdata));
            beats_sent++;
         end
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_tdata  <= pending_reqs.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: the receiver stalls at random and every result beat is checked.
   always @(posedge clock) begin
      alloc_answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_checked++;
            if (awaited_answers.size() == 0) begin
               error_count++;
               if (error_count <= MAX_SHOWN)
                  $display("Unexpected result beat: status %0d first_page %0d",
                           rsp_tdata[2:0], rsp_tdata[12:3]);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_tdata[2:0] !== want.status ||
                   rsp_tdata[12:3] !== want.first_page) begin
                  error_count++;
                  if (error_count <= MAX_SHOWN)
                     $display("Mismatch on beat %0d: status exp %0d got %0d",
                              beats_checked, want.status, rsp_tdata[2:0]);
                  if (error_count <= MAX_SHOWN)
                     $display("   first_page exp %0d got %0d",
                              want.first_page, rsp_tdata[12:3]);
               end else if (want.status == ST_OK) begin
                  allocs_ok++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   function automatic logic [39:0] pack_req(logic [2:0] act, int unsigned req,
                                            int unsigned sp, int unsigned ep);
      return {6'b0, ep[9:0], sp[9:0], req[10:0], act};
   endfunction

   // Waits until every queued beat was accepted and answered, then idles on
   // so the block is surely back in its idle state.
   // The queues are looked at on the falling edge, when the driver and the
   // monitor have settled.
   task automatic drain();
      @(negedge clock);
      while (pending_reqs.size() > 0 || req_tvalid || awaited_answers.size() > 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_page_count(int unsigned v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v[COUNT_W-1:0];
      page_count = v & 11'h7FF;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly small requests so the tree fills and empties many times over.
   function automatic int unsigned pick_size(int unsigned span);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(1, (span < 4) ? span : 4);
      if (r < 85) return $urandom_range(1, span);
      if (r < 90) return span;
      if (r < 95) return 0;
      return $urandom_range(span, 2047);
   endfunction

   // One phase: init, a few reservations, ready, then allocations and frees
   // with some noise mixed in.
   task automatic fill_phase(int unsigned count);
      int unsigned span;
      int unsigned lo;
      int unsigned r;
      span = (page_count == 0 || page_count > 1024) ? 1024 : (1 << log2_up(page_count));
      pending_reqs.push_back(pack_req(ACT_INIT, 0, 0, 0));
      repeat ($urandom_range(0, 3)) begin
         lo = $urandom_range(0, span - 1);
         if ($urandom_range(3) == 0)
            pending_reqs.push_back(pack_req(ACT_RESERVE, 0, $urandom_range(1023),
                                            $urandom_range(1023)));
         else
            pending_reqs.push_back(pack_req(ACT_RESERVE, 0, lo,
                                            $urandom_range(lo, (lo + 3 < span) ? lo + 3 : span - 1)));
      end
      pending_reqs.push_back(pack_req(ACT_READY, 0, 0, 0));
      for (int unsigned k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 52)
            pending_reqs.push_back(pack_req(ACT_ALLOC, pick_size(span), $urandom_range(1023),
                                            $urandom_range(1023)));
         else if (r < 90)
            pending_reqs.push_back(pack_req(ACT_FREE, $urandom_range(2047),
                                            ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                                     : $urandom_range(span - 1),
                                            $urandom_range(1023)));
         else if (r < 93)
            pending_reqs.push_back(pack_req(3'($urandom_range(ACT_BOGUS_LO, ACT_BOGUS_HI)),
                                            $urandom_range(2047), $urandom_range(1023),
                                            $urandom_range(1023)));
         else if (r < 97)
            pending_reqs.push_back(pack_req(($urandom_range(1)) ? ACT_READY : ACT_RESERVE, 0,
                                            $urandom_range(1023), $urandom_range(1023)));
         else begin
            // A fresh init in the middle, followed at once by a new ready.
            pending_reqs.push_back(pack_req(ACT_INIT, 0, 0, 0));
            pending_reqs.push_back(pack_req(ACT_READY, 0, 0, 0));
         end
      end
   endtask

   initial begin
      int unsigned counts[14];
      int unsigned sizes[14];
      counts = '{0, 10, 140, 60, 10, 120, 140, 140, 160, 120, 10, 140, 120, 160};
      sizes  = '{0, 1, 1024, 3, 1025, 2, 5, 100, 512, 17, 2047, 64, 1000, 1024};
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      send_idle   = 31;
      recv_idle   = 46;
      cycle_count = 0;
      error_count = 0;
      beats_sent  = 0;
      beats_checked = 0;
      allocs_ok   = 0;
      for (int unsigned i = 0; i < TREE_SIZE; i++) tree_q[i] = 0;
      is_ready   = 1'b0;
      was_inited = 1'b0;
      top_lvl    = 0;
      page_count = 1024;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Before any init every action except init answers with a phase error,
      // and unknown action codes answer bad range.
      pending_reqs.push_back(pack_req(ACT_ALLOC, 1, 0, 0));
      pending_reqs.push_back(pack_req(ACT_FREE, 0, 0, 0));
      pending_reqs.push_back(pack_req(ACT_RESERVE, 0, 0, 1023));
      pending_reqs.push_back(pack_req(ACT_READY, 0, 0, 0));
      pending_reqs.push_back(pack_req(ACT_BOGUS_HI, 2047, 1023, 1023));
      pending_reqs.push_back(pack_req(ACT_BOGUS_LO, 0, 0, 0));
      drain();

      for (int p = 0; p < 14; p++) begin
         // Receiver idles more in the first third, sender in the second,
         // neither in the last.
         if (p < 5) begin
            send_idle = 31;
            recv_idle = 46;
         end else if (p < 10) begin
            send_idle = 46;
            recv_idle = 31;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_page_count(sizes[p]);
         if (p == 2) begin
            // Full-size tree: the widest fields and the whole-tree request.
            pending_reqs.push_back(pack_req(ACT_INIT, 0, 0, 0));
            pending_reqs.push_back(pack_req(ACT_RESERVE, 0, 1023, 0));
            pending_reqs.push_back(pack_req(ACT_RESERVE, 0, 1020, 1023));
            pending_reqs.push_back(pack_req(ACT_READY, 0, 0, 0));
            pending_reqs.push_back(pack_req(ACT_READY, 0, 0, 0));
            pending_reqs.push_back(pack_req(ACT_ALLOC, 1024, 0, 0));
            pending_reqs.push_back(pack_req(ACT_ALLOC, 0, 0, 0));
            pending_reqs.push_back(pack_req(ACT_ALLOC, 2047, 0, 0));
            pending_reqs.push_back(pack_req(ACT_ALLOC, 512, 0, 0));
            pending_reqs.push_back(pack_req(ACT_ALLOC, 512, 0, 0));
            pending_reqs.push_back(pack_req(ACT_FREE, 0, 1023, 0));
            pending_reqs.push_back(pack_req(ACT_FREE, 0, 0, 0));
            pending_reqs.push_back(pack_req(ACT_FREE, 0, 0, 0));
            pending_reqs.push_back(pack_req(ACT_ALLOC, 3, 0, 0));
         end
         fill_phase(counts[p]);
         if (p == 3) begin
            // Three pages: a free past the top of the tree answers bad range.
            pending_reqs.push_back(pack_req(ACT_FREE, 0, 4, 0));
            pending_reqs.push_back(pack_req(ACT_FREE, 0, 1023, 0));
         end
         drain();
      end

      $display("Ran %0d request beats over several page counts, %0d result beats checked.",
               beats_sent, beats_checked);
      $display("Results with ok status: %0d; mismatches: %0d.", allocs_ok, error_count);
      if (error_count == 0 && awaited_answers.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_ctrl.sv
hdl/bpa_datapath.sv
hdl/buddy_page_allocator.sv
tb/tb_buddy_page_allocator.sv
